// ===== hdl/joystick_thruster_mixer_top_defines.svh =====
// Assertion macros for the joystick thruster mixer checker.
// Each macro expands to one labelled concurrent assertion on the rising edge of clk.
`ifndef JOYSTICK_THRUSTER_MIXER_TOP_DEFINES_SVH
`define JOYSTICK_THRUSTER_MIXER_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset
`define JTM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset
`define JTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset
`define JTM_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/jtm_pkg.sv =====
// Shared types, codes and helpers for the joystick thruster mixer.
// No dependencies; used by the top level and its checker.
`default_nettype none

package jtm_pkg;

  // Field widths
  localparam int AdcBits  = 10;
  localparam int CfgBits  = 10;
  localparam int DutyBits = 8;
  localparam int CmpBits  = (AdcBits > CfgBits) ? AdcBits : CfgBits;

  // Reset values
  localparam logic [CfgBits-1:0]  HighThresholdReset = CfgBits'(600);
  localparam logic [CfgBits-1:0]  LowThresholdReset  = CfgBits'(400);
  localparam logic [DutyBits-1:0] NeutralDutyReset   = DutyBits'(128);
  localparam logic [DutyBits-1:0] DutyMax            = '1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_HIGH_THRESHOLD = 2'd0,
    REG_LOW_THRESHOLD  = 2'd1,
    REG_NEUTRAL_DUTY   = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    MOTION_NONE = 4'd0,
    MOTION_F    = 4'd1,
    MOTION_B    = 4'd2,
    MOTION_FR   = 4'd3,
    MOTION_FL   = 4'd4,
    MOTION_BR   = 4'd5,
    MOTION_BL   = 4'd6,
    MOTION_L    = 4'd7,
    MOTION_R    = 4'd8
  } motion_t;

  typedef enum logic [1:0] {
    HEAVE_NEUTRAL = 2'd0,
    HEAVE_DOWN    = 2'd1,
    HEAVE_UP      = 2'd2
  } heave_code_t;

  typedef enum logic [1:0] {
    LONG_NONE = 2'd0,
    LONG_FWD  = 2'd1,
    LONG_BACK = 2'd2
  } longitudinal_t;

  typedef struct packed {
    logic [AdcBits-1:0] surge_axis;
    logic [AdcBits-1:0] turn_axis;
    logic [AdcBits-1:0] heave_axis;
    logic               reset_button;
  } sample_t;

  typedef struct packed {
    logic [DutyBits-1:0] left_duty;
    logic [DutyBits-1:0] right_duty;
    logic [DutyBits-1:0] heave_duty;
    logic [3:0]          motion_code;
    logic [1:0]          heave_code;
  } result_t;

  // Add a small step, clamp at full scale
  function automatic logic [DutyBits-1:0] sat_inc(input logic [DutyBits-1:0] v,
                                                  input logic [1:0] d);
    logic [DutyBits:0] sum;
    sum = {1'b0, v} + (DutyBits+1)'(d);
    return sum[DutyBits] ? DutyMax : sum[DutyBits-1:0];
  endfunction

  // Subtract a small step, clamp at zero
  function automatic logic [DutyBits-1:0] sat_dec(input logic [DutyBits-1:0] v,
                                                  input logic [1:0] d);
    logic [DutyBits:0] diff;
    diff = {1'b0, v} - (DutyBits+1)'(d);
    return diff[DutyBits] ? '0 : diff[DutyBits-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/joystick_thruster_mixer_top.sv =====
// Joystick thruster mixer: sample register, mixing logic, result register.
// Depends on jtm_pkg for payload structs, codes and saturating helpers.
//
// Usage:
//   Samples enter on in_valid/in_ready, one beat per control sample; each
//   sample yields exactly one result beat on out_valid/out_ready holding the
//   horizontal duties, the heave duty and the decoded motion codes.
//   Thresholds and the neutral duty are written on cfg_valid/cfg_index/
//   cfg_data; cfg_ready is always high and writes to index 3 are dropped.
//   Write configuration only while no sample is in flight.
//   Throughput: one sample per cycle while out_ready keeps up; the mixing
//   step reads and updates the duty registers in the same cycle, so
//   back-to-back samples chain cleanly.
//   Stall: the sample register and the result register each hold one beat,
//   so a new sample is still taken while one result waits; with both full,
//   in_ready falls until out_ready returns.
//   Reset: synchronous on rst; duties return to 128, last fore/aft motion
//   clears, thresholds return to 600 and 400, neutral duty to 128, and both
//   pipeline registers empty.
`default_nettype none

module joystick_thruster_mixer_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire jtm_pkg::sample_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output jtm_pkg::result_t       out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [jtm_pkg::CfgBits-1:0] cfg_data
);

  import jtm_pkg::*;

  // Configuration registers
  logic [CfgBits-1:0]  high_threshold;
  logic [CfgBits-1:0]  low_threshold;
  logic [DutyBits-1:0] neutral_duty;

  // Mixer state
  logic [DutyBits-1:0] left_level, left_level_next;
  logic [DutyBits-1:0] right_level, right_level_next;
  logic [DutyBits-1:0] heave_level, heave_level_next;
  longitudinal_t       last_long, last_long_next;

  // Pipeline registers
  logic        s1_valid;
  sample_t     s1_data;
  logic        s1_advance;
  motion_t     motion_next;
  heave_code_t heave_code_next;

  // Decode helpers
  logic                fwd, back, turn_l, turn_r, heave_dn, heave_up;
  logic [DutyBits-1:0] l0, r0, lr_min, lr_max;
  longitudinal_t       long0;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      high_threshold <= HighThresholdReset;
      low_threshold  <= LowThresholdReset;
      neutral_duty   <= NeutralDutyReset;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_HIGH_THRESHOLD: high_threshold <= cfg_data;
        REG_LOW_THRESHOLD:  low_threshold  <= cfg_data;
        REG_NEUTRAL_DUTY:   neutral_duty   <= cfg_data[DutyBits-1:0];
        default: ;
      endcase
    end
  end

  // Hold the incoming sample
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  // Classify the stick deflections
  always_comb begin
    fwd      = CmpBits'(s1_data.surge_axis) > CmpBits'(high_threshold);
    back     = CmpBits'(s1_data.surge_axis) < CmpBits'(low_threshold);
    turn_l   = CmpBits'(s1_data.turn_axis)  > CmpBits'(high_threshold);
    turn_r   = CmpBits'(s1_data.turn_axis)  < CmpBits'(low_threshold);
    heave_dn = CmpBits'(s1_data.heave_axis) > CmpBits'(high_threshold);
    heave_up = CmpBits'(s1_data.heave_axis) < CmpBits'(low_threshold);

    // Apply the reset button before mixing
    l0     = s1_data.reset_button ? neutral_duty : left_level;
    r0     = s1_data.reset_button ? neutral_duty : right_level;
    long0  = s1_data.reset_button ? LONG_NONE : last_long;
    lr_min = (l0 > r0) ? r0 : l0;
    lr_max = (l0 > r0) ? l0 : r0;
  end

  // Mix the horizontal duties
  always_comb begin
    left_level_next  = l0;
    right_level_next = r0;
    last_long_next   = long0;
    motion_next      = MOTION_NONE;
    if (fwd) begin
      last_long_next = LONG_FWD;
      if (turn_r) begin
        left_level_next  = sat_inc(l0, 2'd2);
        right_level_next = sat_inc(r0, 2'd1);
        motion_next      = MOTION_FR;
      end else if (turn_l) begin
        left_level_next  = sat_inc(l0, 2'd1);
        right_level_next = sat_inc(r0, 2'd2);
        motion_next      = MOTION_FL;
      end else begin
        motion_next = MOTION_F;
        if (l0 == r0) begin
          left_level_next  = sat_inc(l0, 2'd1);
          right_level_next = sat_inc(r0, 2'd1);
        end else if (l0 < neutral_duty || r0 < neutral_duty) begin
          left_level_next  = neutral_duty;
          right_level_next = neutral_duty;
        end else begin
          left_level_next  = lr_min;
          right_level_next = lr_min;
        end
      end
    end else if (back) begin
      last_long_next = LONG_BACK;
      if (turn_r) begin
        left_level_next  = sat_dec(l0, 2'd2);
        right_level_next = sat_dec(r0, 2'd1);
        motion_next      = MOTION_BR;
      end else if (turn_l) begin
        left_level_next  = sat_dec(l0, 2'd1);
        right_level_next = sat_dec(r0, 2'd2);
        motion_next      = MOTION_BL;
      end else begin
        motion_next = MOTION_B;
        if (l0 == r0) begin
          left_level_next  = sat_dec(l0, 2'd1);
          right_level_next = sat_dec(r0, 2'd1);
        end else if (l0 > neutral_duty || r0 > neutral_duty) begin
          left_level_next  = neutral_duty;
          right_level_next = neutral_duty;
        end else begin
          left_level_next  = lr_max;
          right_level_next = lr_max;
        end
      end
    end else if (turn_l) begin
      last_long_next   = LONG_NONE;
      left_level_next  = sat_dec(l0, 2'd1);
      right_level_next = sat_inc(r0, 2'd1);
      motion_next      = MOTION_L;
    end else if (turn_r) begin
      last_long_next   = LONG_NONE;
      left_level_next  = sat_inc(l0, 2'd1);
      right_level_next = sat_dec(r0, 2'd1);
      motion_next      = MOTION_R;
    end else begin
      // Centred: settle according to the last fore/aft move
      case (long0)
        LONG_FWD: begin
          left_level_next  = lr_min;
          right_level_next = lr_min;
        end
        LONG_BACK: begin
          left_level_next  = lr_max;
          right_level_next = lr_max;
        end
        default: begin
          left_level_next  = neutral_duty;
          right_level_next = neutral_duty;
        end
      endcase
    end
  end

  // Ramp or release the heave duty
  always_comb begin
    if (heave_dn) begin
      heave_code_next  = HEAVE_DOWN;
      heave_level_next = sat_inc(heave_level, 2'd1);
    end else if (heave_up) begin
      heave_code_next  = HEAVE_UP;
      heave_level_next = sat_dec(heave_level, 2'd1);
    end else begin
      heave_code_next  = HEAVE_NEUTRAL;
      heave_level_next = neutral_duty;
    end
  end

  // Advance state and result together
  always_ff @(posedge clk) begin
    if (rst) begin
      left_level  <= NeutralDutyReset;
      right_level <= NeutralDutyReset;
      heave_level <= NeutralDutyReset;
      last_long   <= LONG_NONE;
      out_valid   <= 1'b0;
    end else begin
      if (s1_advance) begin
        left_level  <= left_level_next;
        right_level <= right_level_next;
        heave_level <= heave_level_next;
        last_long   <= last_long_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data.left_duty   <= left_level_next;
      out_data.right_duty  <= right_level_next;
      out_data.heave_duty  <= heave_level_next;
      out_data.motion_code <= motion_next;
      out_data.heave_code  <= heave_code_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/jtm_checker.sv =====
// Port-level checks for the joystick thruster mixer, bound to the top level.
// Depends on jtm_pkg and joystick_thruster_mixer_top_defines.svh.
`default_nettype none
`include "joystick_thruster_mixer_top_defines.svh"

module jtm_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire jtm_pkg::result_t out_data
);

  import jtm_pkg::*;

  logic straight_or_centred;

  assign straight_or_centred = out_data.motion_code == MOTION_F ||
                               out_data.motion_code == MOTION_B ||
                               out_data.motion_code == MOTION_NONE;

  // Empty result stage after reset
  `JTM_ASSERT_ALWAYS(a_reset_empties, rst, !out_valid, "result valid right after reset")

  // Hold a stalled result beat
  `JTM_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result beat changed or dropped")

  // Accept input whenever the result stage is free
  `JTM_ASSERT_NOW(a_ready_when_free, !out_valid, in_ready, "input stalled with an empty result stage")

  // Straight and centred moves always leave the duties equal
  `JTM_ASSERT_NOW(a_equal_duties, out_valid && straight_or_centred, out_data.left_duty == out_data.right_duty, "duties differ after straight or centred move")

endmodule

bind joystick_thruster_mixer_top jtm_checker u_jtm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== sim/joystick_thruster_mixer_checker.sv =====
// Scoreboard for the joystick thruster mixer: watches the sample, result and
// register-write channels, predicts each result and compares it field by field.
// Depends on jtm_pkg for the payload structs and code enums.
`default_nettype none

module joystick_thruster_mixer_checker
  import jtm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire sample_t              in_data,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire result_t              out_data,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [CfgBits-1:0]   cfg_data,
  output int                        errors,
  output int                        pending
);

  // Own copy of the registers and of the thruster state
  logic [CfgBits-1:0]  hi_thr;
  logic [CfgBits-1:0]  lo_thr;
  logic [DutyBits-1:0] neutral;
  logic [DutyBits-1:0] left_lv;
  logic [DutyBits-1:0] right_lv;
  logic [DutyBits-1:0] heave_lv;
  longitudinal_t       last_long;

  result_t predicted_mix[$];
  result_t want;

  function automatic logic [DutyBits-1:0] duty_up(logic [DutyBits-1:0] v, int d);
    return (int'(v) + d > 255) ? 8'd255 : 8'(int'(v) + d);
  endfunction

  function automatic logic [DutyBits-1:0] duty_down(logic [DutyBits-1:0] v, int d);
    return (int'(v) < d) ? 8'd0 : 8'(int'(v) - d);
  endfunction

  // Advance the thruster state by one sample and return the duties it leaves
  function automatic result_t mix_sample(sample_t s);
    logic [DutyBits-1:0] l;
    logic [DutyBits-1:0] r;
    logic                tl;
    logic                tr;
    motion_t             mc;
    heave_code_t         hc;
    result_t             res;
    tl = s.turn_axis > hi_thr;
    tr = s.turn_axis < lo_thr;
    if (s.reset_button) begin
      left_lv   = neutral;
      right_lv  = neutral;
      last_long = LONG_NONE;
    end
    l = left_lv;
    r = right_lv;
    if (s.surge_axis > hi_thr) begin
      last_long = LONG_FWD;
      if (tr) begin
        l  = duty_up(l, 2);
        r  = duty_up(r, 1);
        mc = MOTION_FR;
      end else if (tl) begin
        l  = duty_up(l, 1);
        r  = duty_up(r, 2);
        mc = MOTION_FL;
      end else begin
        mc = MOTION_F;
        // equal duties creep up; unequal ones close to the smaller or snap to neutral
        if (l == r) begin
          l = duty_up(l, 1);
          r = l;
        end else if (l < neutral || r < neutral) begin
          l = neutral;
          r = neutral;
        end else if (l > r) begin
          l = r;
        end else begin
          r = l;
        end
      end
    end else if (s.surge_axis < lo_thr) begin
      last_long = LONG_BACK;
      if (tr) begin
        l  = duty_down(l, 2);
        r  = duty_down(r, 1);
        mc = MOTION_BR;
      end else if (tl) begin
        l  = duty_down(l, 1);
        r  = duty_down(r, 2);
        mc = MOTION_BL;
      end else begin
        mc = MOTION_B;
        if (l == r) begin
          l = duty_down(l, 1);
          r = l;
        end else if (l > neutral || r > neutral) begin
          l = neutral;
          r = neutral;
        end else if (l > r) begin
          r = l;
        end else begin
          l = r;
        end
      end
    end else if (tl) begin
      last_long = LONG_NONE;
      r  = duty_up(r, 1);
      l  = duty_down(l, 1);
      mc = MOTION_L;
    end else if (tr) begin
      last_long = LONG_NONE;
      l  = duty_up(l, 1);
      r  = duty_down(r, 1);
      mc = MOTION_R;
    end else begin
      // stick centred: settle according to the last fore/aft move
      mc = MOTION_NONE;
      case (last_long)
        LONG_FWD: begin
          if (l > r) l = r; else r = l;
        end
        LONG_BACK: begin
          if (l > r) r = l; else l = r;
        end
        default: begin
          l = neutral;
          r = neutral;
        end
      endcase
    end
    left_lv  = l;
    right_lv = r;

    if (s.heave_axis > hi_thr) begin
      hc       = HEAVE_DOWN;
      heave_lv = duty_up(heave_lv, 1);
    end else if (s.heave_axis < lo_thr) begin
      hc       = HEAVE_UP;
      heave_lv = duty_down(heave_lv, 1);
    end else begin
      hc       = HEAVE_NEUTRAL;
      heave_lv = neutral;
    end

    res.left_duty   = l;
    res.right_duty  = r;
    res.heave_duty  = heave_lv;
    res.motion_code = mc;
    res.heave_code  = hc;
    return res;
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endtask

  // Track register writes, compare result beats, then queue the prediction
  always @(posedge clk) begin
    if (rst) begin
      hi_thr    = HighThresholdReset;
      lo_thr    = LowThresholdReset;
      neutral   = NeutralDutyReset;
      left_lv   = NeutralDutyReset;
      right_lv  = NeutralDutyReset;
      heave_lv  = NeutralDutyReset;
      last_long = LONG_NONE;
      errors    = 0;
      predicted_mix.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HIGH_THRESHOLD: hi_thr  = cfg_data;
          REG_LOW_THRESHOLD:  lo_thr  = cfg_data;
          REG_NEUTRAL_DUTY:   neutral = cfg_data[DutyBits-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (predicted_mix.size() == 0) begin
          $error("result beat with no sample outstanding");
          errors++;
        end else begin
          want = predicted_mix.pop_front();
          check_field("left_duty", want.left_duty, out_data.left_duty);
          check_field("right_duty", want.right_duty, out_data.right_duty);
          check_field("heave_duty", want.heave_duty, out_data.heave_duty);
          check_field("motion_code", 8'(want.motion_code), 8'(out_data.motion_code));
          check_field("heave_code", 8'(want.heave_code), 8'(out_data.heave_code));
        end
      end
      if (in_valid && in_ready) predicted_mix.push_back(mix_sample(in_data));
    end
    pending = predicted_mix.size();
  end

endmodule

`default_nettype wire

// ===== sim/joystick_thruster_mixer_top_test.sv =====
// Testbench top for the joystick thruster mixer: clock, reset, sample and
// register-write stimulus, result back-pressure and the final verdict.
// Depends on jtm_pkg, joystick_thruster_mixer_top and joystick_thruster_mixer_checker.
`default_nettype none

module joystick_thruster_mixer_top_test;
  import jtm_pkg::*;

  typedef enum int {AXIS_MID, AXIS_ABOVE, AXIS_BELOW} axis_zone_t;
  typedef enum int {SINK_FREE, SINK_COIN, SINK_SPARSE, SINK_HOLD} sink_mode_t;

  localparam logic [1:0] RegUnused = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  sample_t            in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  result_t            out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [CfgBits-1:0] cfg_data = '0;
  int                 errors;
  int                 pending;

  // Thresholds currently programmed, used to aim the axis readings
  int                 thr_hi = 600;
  int                 thr_lo = 400;
  int                 burst_left = 0;
  int                 hold_left = 0;
  sink_mode_t         sink_mode = SINK_FREE;

  joystick_thruster_mixer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  joystick_thruster_mixer_checker scoreboard (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result back-pressure: segments of free flow, coin toss, sparse and full hold
  always @(negedge clk) begin
    if (hold_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      hold_left = (sink_mode == SINK_HOLD) ? $urandom_range(1, 30) : $urandom_range(1, 60);
    end
    hold_left--;
    case (sink_mode)
      SINK_FREE:   out_ready = 1'b1;
      SINK_COIN:   out_ready = 1'($urandom_range(0, 1));
      SINK_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
      default:     out_ready = 1'b0;
    endcase
  end

  function automatic sample_t sample_of(int surge, int turn, int heave, int button);
    sample_t s;
    s.surge_axis   = 10'(surge);
    s.turn_axis    = 10'(turn);
    s.heave_axis   = 10'(heave);
    s.reset_button = 1'(button);
    return s;
  endfunction

  // Pick a reading in the wanted zone, often right on a threshold edge
  function automatic logic [AdcBits-1:0] axis_in(axis_zone_t zone);
    int pick;
    pick = $urandom_range(0, 7);
    case (zone)
      AXIS_ABOVE: begin
        if (thr_hi >= 1023) return 10'($urandom);
        if (pick == 0) return 10'(thr_hi + 1);
        if (pick == 1) return 10'd1023;
        return 10'($urandom_range(1023, thr_hi + 1));
      end
      AXIS_BELOW: begin
        if (thr_lo == 0) return 10'($urandom);
        if (pick == 0) return 10'(thr_lo - 1);
        if (pick == 1) return 10'd0;
        return 10'($urandom_range(thr_lo - 1, 0));
      end
      default: begin
        if (thr_lo > thr_hi) return 10'($urandom);
        if (pick == 0) return 10'(thr_lo);
        if (pick == 1) return 10'(thr_hi);
        return 10'($urandom_range(thr_hi, thr_lo));
      end
    endcase
  endfunction

  // Offer one sample beat; bursts of random length with random gaps between
  task automatic push_sample(sample_t s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_data  = s;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
  endtask

  // Hold off the sender until every result has come back
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    cfg_index = idx;
    cfg_data  = 10'(value);
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Runs of one stick position with fresh readings, plus some raw noise
  task automatic random_run(int count);
    int         done;
    int         run_len;
    motion_t    move;
    axis_zone_t sz;
    axis_zone_t tz;
    axis_zone_t hz;
    sample_t    s;
    done = 0;
    while (done < count) begin
      move    = motion_t'($urandom_range(0, 8));
      hz      = axis_zone_t'($urandom_range(0, 2));
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 20);
      case (move)
        MOTION_F:  begin sz = AXIS_ABOVE; tz = AXIS_MID;   end
        MOTION_B:  begin sz = AXIS_BELOW; tz = AXIS_MID;   end
        MOTION_FR: begin sz = AXIS_ABOVE; tz = AXIS_BELOW; end
        MOTION_FL: begin sz = AXIS_ABOVE; tz = AXIS_ABOVE; end
        MOTION_BR: begin sz = AXIS_BELOW; tz = AXIS_BELOW; end
        MOTION_BL: begin sz = AXIS_BELOW; tz = AXIS_ABOVE; end
        MOTION_L:  begin sz = AXIS_MID;   tz = AXIS_ABOVE; end
        MOTION_R:  begin sz = AXIS_MID;   tz = AXIS_BELOW; end
        default:   begin sz = AXIS_MID;   tz = AXIS_MID;   end
      endcase
      for (int k = 0; k < run_len && done < count; k++) begin
        if ($urandom_range(0, 6) == 0) begin
          s = sample_of($urandom, $urandom, $urandom, $urandom_range(0, 1));
        end else begin
          s.surge_axis   = axis_in(sz);
          s.turn_axis    = axis_in(tz);
          s.heave_axis   = axis_in(hz);
          s.reset_button = ($urandom_range(0, 39) == 0);
        end
        push_sample(s);
        done++;
        if ($urandom_range(0, 199) == 0) drain_results();
      end
    end
  endtask

  // Reprogram all registers while idle, then run random samples
  task automatic run_phase(int h, int l, int n, int count);
    drain_results();
    write_reg(REG_HIGH_THRESHOLD, h);
    write_reg(REG_LOW_THRESHOLD, l);
    write_reg(REG_NEUTRAL_DUTY, n | ($urandom_range(0, 3) << 8));
    write_reg(RegUnused, $urandom_range(0, 1023));
    thr_hi = h;
    thr_lo = l;
    random_run(count);
  endtask

  initial begin
    int lo;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed walk through every move at the reset thresholds
    push_sample(sample_of(512, 512, 512, 0));
    push_sample(sample_of(1023, 512, 1023, 0));
    push_sample(sample_of(1023, 0, 0, 0));
    push_sample(sample_of(601, 512, 600, 0));
    push_sample(sample_of(1023, 1023, 601, 0));
    push_sample(sample_of(512, 512, 399, 0));
    push_sample(sample_of(600, 1023, 400, 0));
    push_sample(sample_of(400, 512, 512, 0));
    push_sample(sample_of(399, 0, 512, 0));
    push_sample(sample_of(0, 1023, 512, 0));
    push_sample(sample_of(0, 512, 1023, 0));
    push_sample(sample_of(512, 1023, 0, 0));
    push_sample(sample_of(0, 512, 512, 0));
    push_sample(sample_of(512, 0, 512, 0));
    push_sample(sample_of(1023, 512, 512, 0));
    push_sample(sample_of(1023, 0, 512, 0));
    push_sample(sample_of(0, 512, 512, 0));
    push_sample(sample_of(0, 0, 512, 0));
    push_sample(sample_of(512, 512, 512, 0));
    push_sample(sample_of(1023, 0, 512, 1));
    push_sample(sample_of(1023, 512, 1023, 1));
    push_sample(sample_of(0, 1023, 0, 1));

    // Threshold extremes, crossed thresholds and duty extremes
    run_phase(1023, 0, 0, 40);
    run_phase(0, 1023, 255, 60);
    run_phase(600, 400, 255, 120);
    run_phase(700, 300, 0, 120);
    run_phase(100, 900, 60, 80);
    repeat (4) begin
      lo = $urandom_range(0, 700);
      run_phase($urandom_range(lo, 1023), lo, $urandom_range(0, 255), 110);
    end
    run_phase(600, 400, 128, 60);

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS joystick_thruster_mixer_top");
    end else begin
      $display("FAIL joystick_thruster_mixer_top");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #8_000_000;
    $display("FAIL joystick_thruster_mixer_top");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/jtm_pkg.sv
hdl/joystick_thruster_mixer_top.sv
hdl/jtm_checker.sv
sim/joystick_thruster_mixer_checker.sv
sim/joystick_thruster_mixer_top_test.sv
